### hdl/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 transcoder.
// Holds the decode action codes, the decoder result struct and the UTF-16 constants.
// No dependencies.
package u8u16_pkg;

  typedef logic [1:0] act_kind_t;

  localparam act_kind_t ACT_UNIT = 2'd0;  // one code unit
  localparam act_kind_t ACT_PAIR = 2'd1;  // surrogate pair
  localparam act_kind_t ACT_HOLD = 2'd2;  // keep bytes for the next beat

  localparam logic [15:0] SURR_HI_BASE = 16'hD800;
  localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
  localparam logic [15:0] REPLACEMENT  = 16'hFFFD;
  localparam logic [20:0] SUPP_BASE    = 21'h010000;
  localparam logic [20:0] BMP_MAX      = 21'h00FFFF;
  localparam logic [20:0] CODE_MAX     = 21'h10FFFF;

  typedef struct packed {
    act_kind_t   kind;
    logic [15:0] unit_hi;   // single unit, or high surrogate
    logic [15:0] unit_lo;   // low surrogate
    logic [2:0]  nbytes;    // bytes of the character
    logic [2:0]  adv;       // bytes consumed by this action
  } dec_res_t;

endpackage

### hdl/u8u16_byte_if.sv
// Byte channel of the transcoder: valid/ready plus one UTF-8 byte and its end-of-text mark.
// No dependencies.
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, data_byte, end_of_text, input ready);
  modport sink   (input valid, data_byte, end_of_text, output ready);
endinterface

### hdl/u8u16_unit_if.sv
// Code unit channel of the transcoder: valid/ready plus one UTF-16 unit and its tags.
// No dependencies.
interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [2:0]  char_bytes;
  logic        last_of_run;

  modport source (output valid, code_unit, char_bytes, last_of_run, input ready);
  modport sink   (input valid, code_unit, char_bytes, last_of_run, output ready);
endinterface

### hdl/u8u16_decode.sv
// Shared decode unit: classifies the byte window at the current position and
// builds the code point, the unit(s) and the byte count. Depends on u8u16_pkg.
module u8u16_decode import u8u16_pkg::*; (
  input  logic [3:0][7:0] win,
  input  logic [2:0]      avail,
  input  logic            eot,
  output dec_res_t        res
);

  always_comb begin
    logic [7:0]  lead;
    logic [2:0]  need;
    logic [2:0]  len;
    logic        single;
    logic        bad;
    logic [20:0] cp;
    logic [20:0] v;

    lead   = win[0];
    single = (lead < 8'hC0) || (lead >= 8'hF8);
    if (lead >= 8'hF0) begin
      need = 3'd4;
    end else if (lead >= 8'hE0) begin
      need = 3'd3;
    end else begin
      need = 3'd2;
    end
    bad = ((avail > 3'd1) && (win[1][7:6] != 2'b10)) ||
          ((need > 3'd2) && (avail > 3'd2) && (win[2][7:6] != 2'b10)) ||
          ((need > 3'd3) && (avail > 3'd3) && (win[3][7:6] != 2'b10));

    if (single || bad) begin
      len = 3'd1;
    end else if (avail >= need) begin
      len = need;
    end else begin
      len = avail;
    end

    case (len)
      3'd2:    cp = {10'd0, lead[4:0], win[1][5:0]};
      3'd3:    cp = {5'd0, lead[3:0], win[1][5:0], win[2][5:0]};
      3'd4:    cp = {lead[2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
      default: cp = {13'd0, lead};
    endcase
    v = cp - SUPP_BASE;

    res.kind    = ACT_UNIT;
    res.unit_hi = cp[15:0];
    res.unit_lo = SURR_LO_BASE | {6'd0, v[9:0]};
    res.nbytes  = len;
    res.adv     = len;

    if (!single && !bad && (avail < need) && !eot) begin
      // incomplete sequence: park it
      res.kind = ACT_HOLD;
      res.adv  = avail;
    end else if (cp > CODE_MAX) begin
      res.unit_hi = REPLACEMENT;
    end else if (cp > BMP_MAX) begin
      res.kind    = ACT_PAIR;
      res.unit_hi = SURR_HI_BASE | {6'd0, v[19:10]};
    end
  end

endmodule

### hdl/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 transcoder: byte buffer, sequencer, unit staging
// and output register. Depends on u8u16_pkg, u8u16_byte_if, u8u16_unit_if, u8u16_decode.
// Flow: a byte whose beat yields a single unit and nothing else is buffered, decoded and written
//   straight to the output register; otherwise each unit is staged until the next action is decoded.
// A new byte is only taken in idle, once all units of the last byte are decoded. The shared
//   decode unit handles one action (unit, surrogate half or hold) per cycle while the output
//   register can accept a unit; a stall on the unit channel holds it.
// Reset: clears the sequencer, pending count, staging and output valid; held bytes keep
//   whatever they had and are only read after being written.
module utf8_to_utf16_transcoder import u8u16_pkg::*; (
  input logic          clk,
  input logic          rst,
  u8u16_byte_if.sink   bytes,
  u8u16_unit_if.source units
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic            state;
  logic [3:0][7:0] seq_bytes;   // held bytes plus the new byte
  logic [2:0]      cnt;         // bytes in seq_bytes (held count when idle)
  logic [2:0]      pos;         // decode position
  logic            eot;
  logic            half;        // high surrogate already sent

  // one-unit staging so the final unit of a beat can be tagged
  logic            pend_valid;
  logic [15:0]     pend_unit;
  logic [2:0]      pend_bytes;

  logic            out_valid;
  logic [15:0]     out_unit;
  logic [2:0]      out_bytes;
  logic            out_last;

  logic [3:0][7:0] win;
  logic [2:0]      avail;
  dec_res_t        dec;
  logic            can_push;
  logic            fin;
  logic [15:0]     cur_unit;
  logic [2:0]      pos_adv;

  // Window of bytes starting at the decode position; out-of-range slots read zero.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [2:0] idx;
      idx = pos + 3'(i);
      win[i] = idx[2] ? 8'h00 : seq_bytes[idx[1:0]];
    end
  end

  assign avail = cnt - pos;

  u8u16_decode u_decode (
    .win   (win),
    .avail (avail),
    .eot   (eot),
    .res   (dec)
  );

  assign can_push = !out_valid || units.ready;
  assign cur_unit = half ? dec.unit_lo : dec.unit_hi;
  assign pos_adv  = pos + dec.adv;
  // this action ends the beat's work
  assign fin      = (pos_adv == cnt) && ((dec.kind == ACT_UNIT) || half);

  assign bytes.ready       = (state == ST_IDLE);
  assign units.valid       = out_valid;
  assign units.code_unit   = out_unit;
  assign units.char_bytes  = out_bytes;
  assign units.last_of_run = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      pos        <= '0;
      half       <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (units.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          // append the new byte behind any held bytes
          if (bytes.valid) begin
            seq_bytes[cnt[1:0]] <= bytes.data_byte;
            cnt   <= cnt + 3'd1;
            pos   <= '0;
            eot   <= bytes.end_of_text;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (can_push) begin
            if (pos == cnt) begin
              // drain the staged unit as the last of the beat
              out_valid  <= 1'b1;
              out_unit   <= pend_unit;
              out_bytes  <= pend_bytes;
              out_last   <= 1'b1;
              pend_valid <= 1'b0;
              cnt        <= '0;
              state      <= ST_IDLE;
            end else if (dec.kind == ACT_HOLD) begin
              // park the partial sequence at the front of the buffer
              if (pend_valid) begin
                out_valid <= 1'b1;
                out_unit  <= pend_unit;
                out_bytes <= pend_bytes;
                out_last  <= 1'b1;
              end
              pend_valid <= 1'b0;
              for (int i = 0; i < 3; i++) begin
                seq_bytes[i] <= win[i];
              end
              cnt   <= avail;
              state <= ST_IDLE;
            end else begin
              if (pend_valid) begin
                out_valid <= 1'b1;
                out_unit  <= pend_unit;
                out_bytes <= pend_bytes;
                out_last  <= 1'b0;
              end
              if (fin && !pend_valid) begin
                // known final unit with nothing staged: send it directly
                out_valid  <= 1'b1;
                out_unit   <= cur_unit;
                out_bytes  <= dec.nbytes;
                out_last   <= 1'b1;
                cnt        <= '0;
                state      <= ST_IDLE;
              end else begin
                pend_valid <= 1'b1;
                pend_unit  <= cur_unit;
                pend_bytes <= dec.nbytes;
              end
              if ((dec.kind == ACT_PAIR) && !half) begin
                half <= 1'b1;
              end else begin
                half <= 1'b0;
                pos  <= pos_adv;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Idle leaves nothing staged and at most three held bytes.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!pend_valid && !half && (cnt <= 3'd3)))
    else $error("idle with staged unit or bad held count");

  // A pending low surrogate only exists while the window still decodes to a pair.
  a_half_pair: assert property (@(posedge clk) disable iff (rst)
    half |-> (state == ST_RUN) && (dec.kind == ACT_PAIR))
    else $error("surrogate half flag without a pair");

  // While running, either bytes remain or a staged unit waits to drain.
  a_run_work: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> ((pos < cnt) || pend_valid))
    else $error("running with no work left");

  // Every unit carries a byte count of one to four.
  a_bytes_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_bytes != 3'd0) && (out_bytes <= 3'd4)))
    else $error("char_bytes out of range");

  // A beat is only taken while nothing is staged.
  a_accept_empty: assert property (@(posedge clk) disable iff (rst)
    (bytes.valid && bytes.ready) |=> (state == ST_RUN) && !pend_valid && (pos == 3'd0))
    else $error("beat accepted with stale state");

endmodule
